FILE: hw/rtl/bpfa_pkg.sv
// Package for the bitmap page frame allocator.
// Holds the action codes, controller states, field widths and the command and
// status structs that join the controller to the datapath. No dependencies.
package bpfa_pkg;

  localparam int unsigned ActW       = 2;
  localparam int unsigned FrameW     = 12;
  localparam int unsigned LenW       = 13;
  localparam int unsigned CntW       = 13;
  localparam int unsigned FrameTotal = 4096;

  typedef enum logic [ActW-1:0] {
    ACT_ALLOC   = 2'd0,
    ACT_FREE    = 2'd1,
    ACT_RELEASE = 2'd2,
    ACT_RESERVE = 2'd3
  } act_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_UPD_INIT,
    ST_UPDATE,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic clr;
    logic load;
    logic scan;
    logic upd_init;
    logic update;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic scan_hit;
    logic scan_miss;
    logic upd_end;
  } sts_t;

endpackage

FILE: hw/rtl/bpfa_ctrl.sv
// Controller state machine of the bitmap page frame allocator.
// Sequences clearing, search and run update, and owns both handshakes.
// Depends on bpfa_pkg.
module bpfa_ctrl import bpfa_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [ActW-1:0]  action_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  input  sts_t             sts_i,
  output cmd_t             cmd_o
);

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: begin
        if (sts_i.clr_last) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = (act_e'(action_i) == ACT_ALLOC) ? ST_SCAN : ST_UPDATE;
        end
      end
      ST_SCAN: begin
        if (sts_i.scan_hit) begin
          state_d = ST_UPD_INIT;
        end else if (sts_i.scan_miss) begin
          state_d = ST_DONE;
        end
      end
      ST_UPD_INIT: state_d = ST_UPDATE;
      ST_UPDATE: begin
        if (sts_i.upd_end) state_d = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_q || out_ready_i) state_d = ST_IDLE;
      end
      default: state_d = ST_CLEAR;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_CLEAR:    cmd_o.clr = 1'b1;
      ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      ST_SCAN:     cmd_o.scan = 1'b1;
      ST_UPD_INIT: cmd_o.upd_init = 1'b1;
      ST_UPDATE:   cmd_o.update = 1'b1;
      ST_DONE:     cmd_o.emit = !out_valid_q || out_ready_i;
      default:     cmd_o = '0;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) out_valid_d = 1'b0;
    if (cmd_o.emit) out_valid_d = 1'b1;
  end

  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

FILE: hw/rtl/bpfa_dp.sv
// Datapath of the bitmap page frame allocator: taken-bit map memory, first-fit
// search over one map word per cycle, run update with flip counting, counters
// and result register. Depends on bpfa_pkg.
module bpfa_dp import bpfa_pkg::*; #(
  parameter int unsigned MAP_WORD_BITS = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cmd_t              cmd_i,
  output sts_t              sts_o,
  input  logic [ActW-1:0]   action_i,
  input  logic [FrameW-1:0] first_frame_in_i,
  input  logic [LenW-1:0]   run_length_i,
  output logic [FrameW-1:0] first_frame_out_o,
  output logic              found_o,
  output logic [CntW-1:0]   free_count_o,
  output logic [CntW-1:0]   used_count_o
);

  localparam int unsigned W         = MAP_WORD_BITS;
  localparam int unsigned MapWords  = (FrameTotal + W - 1) / W;
  localparam int unsigned AW        = (MapWords > 1) ? $clog2(MapWords) : 1;
  localparam int unsigned AW1       = $clog2(MapWords + 1);
  localparam int unsigned FCW       = $clog2(FrameTotal + 1);
  localparam int unsigned PW        = ((FCW > 13) ? FCW : 13) + 1;
  localparam int unsigned CW        = $clog2(W + 1);
  localparam int unsigned SW        = ((FCW > CW) ? FCW : CW) + 1;

  logic [W-1:0]   mem [MapWords];
  logic [W-1:0]   rdata_q;
  logic [AW1-1:0] p_addr_q;
  logic [PW-1:0]  p_base_q;
  logic           pv_q, pv_d;
  logic [AW1-1:0] rd_addr_q, rd_addr_d;
  logic [PW-1:0]  rd_base_q, rd_base_d;

  act_e           act_q;
  logic [LenW-1:0] len_q;
  logic [PW-1:0]  lo_q, hi_q;
  logic [PW-1:0]  run_q, start_q, start_base_q;
  logic [AW1-1:0] start_wd_q;
  logic           hit_q;
  logic [FCW-1:0] free_q, free_d, used_q, used_d;

  logic           issue;
  logic           mem_we;
  logic [AW-1:0]  mem_wa;
  logic [W-1:0]   mem_wd;

  logic [PW-1:0]  run_v, st_v, sb_v;
  logic [AW1-1:0] sw_v;
  logic           hit_v;

  logic [W-1:0]   mask, flip, new_word;
  logic [CW-1:0]  nflip;
  logic           set_op;
  logic [PW-1:0]  load_end;
  logic [SW-1:0]  free_w, used_w, flip_w;
  logic [FCW-1:0] free_up, free_dn, used_up, used_dn;

  // First-fit search over the word in the read register.
  always_comb begin
    run_v = run_q;
    st_v  = start_q;
    sw_v  = start_wd_q;
    sb_v  = start_base_q;
    hit_v = 1'b0;
    for (int b = 0; b < W; b++) begin
      if (!hit_v) begin
        if (rdata_q[b]) begin
          run_v = '0;
          st_v  = p_base_q + PW'(b + 1);
          if (b == W - 1) begin
            sw_v = p_addr_q + AW1'(1);
            sb_v = p_base_q + PW'(W);
          end else begin
            sw_v = p_addr_q;
            sb_v = p_base_q;
          end
        end else begin
          run_v = run_v + PW'(1);
          if (run_v == PW'(len_q)) hit_v = 1'b1;
        end
      end
    end
  end

  // Run update of the word in the read register.
  always_comb begin
    logic [PW-1:0] fr;
    fr     = '0;
    mask   = '0;
    nflip  = '0;
    for (int b = 0; b < W; b++) begin
      fr      = p_base_q + PW'(b);
      mask[b] = (fr >= lo_q) && (fr < hi_q);
    end
    set_op   = (act_q == ACT_ALLOC) || (act_q == ACT_RESERVE);
    flip     = set_op ? (mask & ~rdata_q) : (mask & rdata_q);
    new_word = set_op ? (rdata_q | mask) : (rdata_q & ~mask);
    for (int b = 0; b < W; b++) begin
      nflip = nflip + CW'(flip[b]);
    end
  end

  always_comb begin
    free_w  = SW'(free_q);
    used_w  = SW'(used_q);
    flip_w  = SW'(nflip);
    free_dn = (free_w > flip_w) ? FCW'(free_w - flip_w) : '0;
    used_dn = (used_w > flip_w) ? FCW'(used_w - flip_w) : '0;
    free_up = ((free_w + flip_w) > SW'(FrameTotal)) ? FCW'(FrameTotal) : FCW'(free_w + flip_w);
    used_up = ((used_w + flip_w) > SW'(FrameTotal)) ? FCW'(FrameTotal) : FCW'(used_w + flip_w);
    free_d  = free_q;
    used_d  = used_q;
    if (cmd_i.update && pv_q) begin
      free_d = set_op ? free_dn : free_up;
      case (act_q)
        ACT_ALLOC: used_d = used_up;
        ACT_FREE:  used_d = used_dn;
        default:   used_d = used_q;
      endcase
    end
  end

  always_comb begin
    load_end = PW'(first_frame_in_i) + PW'(run_length_i);
    if (load_end > PW'(FrameTotal)) load_end = PW'(FrameTotal);
  end

  assign issue = (rd_addr_q != AW1'(MapWords)) && (cmd_i.scan || (rd_base_q < hi_q));

  always_comb begin
    rd_addr_d = rd_addr_q;
    rd_base_d = rd_base_q;
    pv_d      = 1'b0;
    if (cmd_i.clr) begin
      rd_addr_d = rd_addr_q + AW1'(1);
    end else if (cmd_i.load) begin
      rd_addr_d = '0;
      rd_base_d = '0;
    end else if (cmd_i.upd_init) begin
      rd_addr_d = start_wd_q;
      rd_base_d = start_base_q;
    end else if ((cmd_i.scan || cmd_i.update) && issue) begin
      rd_addr_d = rd_addr_q + AW1'(1);
      rd_base_d = rd_base_q + PW'(W);
      pv_d      = 1'b1;
    end
  end

  assign mem_we = cmd_i.clr || (cmd_i.update && pv_q);
  assign mem_wa = cmd_i.clr ? rd_addr_q[AW-1:0] : p_addr_q[AW-1:0];
  assign mem_wd = cmd_i.clr ? {W{1'b1}} : new_word;

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    rdata_q  <= mem[rd_addr_q[AW-1:0]];
    p_addr_q <= rd_addr_q;
    p_base_q <= rd_base_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pv_q      <= 1'b0;
      rd_addr_q <= '0;
      rd_base_q <= '0;
      free_q    <= '0;
      used_q    <= '0;
    end else begin
      pv_q      <= pv_d;
      rd_addr_q <= rd_addr_d;
      rd_base_q <= rd_base_d;
      free_q    <= free_d;
      used_q    <= used_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      act_q        <= act_e'(action_i);
      len_q        <= run_length_i;
      lo_q         <= PW'(first_frame_in_i);
      hi_q         <= load_end;
      run_q        <= '0;
      start_q      <= '0;
      start_wd_q   <= '0;
      start_base_q <= '0;
      hit_q        <= 1'b0;
    end else if (cmd_i.upd_init) begin
      lo_q <= start_q;
      hi_q <= start_q + PW'(len_q);
    end else if (cmd_i.scan && pv_q) begin
      run_q        <= run_v;
      start_q      <= st_v;
      start_wd_q   <= sw_v;
      start_base_q <= sb_v;
      if (hit_v) hit_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      first_frame_out_o <= ((act_q == ACT_ALLOC) && hit_q) ? FrameW'(start_q) : '0;
      found_o           <= (act_q != ACT_ALLOC) || hit_q;
      free_count_o      <= CntW'(free_q);
      used_count_o      <= CntW'(used_q);
    end
  end

  assign sts_o.clr_last  = (rd_addr_q == AW1'(MapWords - 1));
  assign sts_o.scan_hit  = pv_q && hit_v;
  assign sts_o.scan_miss = pv_q && !hit_v && (p_addr_q == AW1'(MapWords - 1));
  assign sts_o.upd_end   = !pv_q && !issue;

endmodule

FILE: hw/rtl/bitmap_page_frame_allocator.sv
// Bitmap first-fit page frame allocator for FrameTotal frames with one taken
// bit per frame, kept in an on-chip map of MAP_WORD_BITS-bit words, plus free
// and used frame counts. After reset the block runs a clearing pass over every
// map word (512 at the default word width) that marks every frame taken;
// in_ready_o stays low during it. One transaction is handled at a time and the
// map memory port sets its pace: one map word per cycle. An allocation scans
// from word 0 until the run fits (up to the whole map) and then rewrites the
// words of the run; free, release and reserve walk from word 0 to the last word
// of the run. A finished result sits in the output register while the next
// transaction is already accepted; if the previous result is still unread, the
// block waits before finishing.
// Depends on bpfa_pkg, bpfa_ctrl and bpfa_dp.
module bitmap_page_frame_allocator import bpfa_pkg::*; #(
  parameter int unsigned MAP_WORD_BITS = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [ActW-1:0]   action_i,
  input  logic [FrameW-1:0] first_frame_in_i,
  input  logic [LenW-1:0]   run_length_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [FrameW-1:0] first_frame_out_o,
  output logic              found_o,
  output logic [CntW-1:0]   free_count_o,
  output logic [CntW-1:0]   used_count_o
);

  cmd_t cmd;
  sts_t sts;

  bpfa_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .action_i    (action_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  bpfa_dp #(
    .MAP_WORD_BITS (MAP_WORD_BITS)
  ) u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .sts_o             (sts),
    .action_i          (action_i),
    .first_frame_in_i  (first_frame_in_i),
    .run_length_i      (run_length_i),
    .first_frame_out_o (first_frame_out_o),
    .found_o           (found_o),
    .free_count_o      (free_count_o),
    .used_count_o      (used_count_o)
  );

endmodule

FILE: tb/bitmap_page_frame_allocator_tb.sv
// Self-checking testbench for bitmap_page_frame_allocator. It keeps its own
// first-fit frame map to predict each result and uses random handshake idling.
// Depends on bpfa_pkg and the allocator RTL.
`timescale 1ns / 1ps

module bitmap_page_frame_allocator_tb;
  import bpfa_pkg::*;

  localparam int unsigned Frames   = 4096;
  localparam int unsigned IdleLimit = 20000;

  typedef struct packed {
    logic [FrameW-1:0] first_frame;
    logic              found;
    logic [CntW-1:0]   free_count;
    logic [CntW-1:0]   used_count;
  } status_t;

  typedef struct packed {
    act_e              act;
    logic [FrameW-1:0] first;
    logic [LenW-1:0]   len;
    logic              drain;
    status_t           status;
  } op_t;

  typedef struct packed {
    logic [FrameW-1:0] start;
    logic [LenW-1:0]   len;
  } run_t;

  logic              clk_i;
  logic              rst_ni;
  logic              in_valid_i;
  logic              in_ready_o;
  logic [ActW-1:0]   action_i;
  logic [FrameW-1:0] first_frame_in_i;
  logic [LenW-1:0]   run_length_i;
  logic              out_valid_o;
  logic              out_ready_i;
  logic [FrameW-1:0] first_frame_out_o;
  logic              found_o;
  logic [CntW-1:0]   free_count_o;
  logic [CntW-1:0]   used_count_o;

  bitmap_page_frame_allocator dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .action_i         (action_i),
    .first_frame_in_i (first_frame_in_i),
    .run_length_i     (run_length_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .first_frame_out_o(first_frame_out_o),
    .found_o          (found_o),
    .free_count_o     (free_count_o),
    .used_count_o     (used_count_o)
  );

  bit      frame_taken [Frames];
  int      model_free;
  int      model_used;
  int      alloc_hits;
  int      alloc_misses;
  int      run_updates;

  op_t     pending_ops [$];
  status_t awaited_status [$];
  run_t    live_runs [$];
  op_t     cur_op;

  logic    in_fire;
  logic    out_fire;
  int      send_gap;
  int      recv_stall;
  bit      burst_mode;
  int      idle_cycles;
  int      errors;
  int      checked;

  // Works out the status of one transaction and advances the frame map.
  function automatic status_t predict_status(act_e act, logic [FrameW-1:0] first,
                                             logic [LenW-1:0] len);
    status_t st;
    int      f;
    int      run;
    int      start;
    int      stop;
    bit      hit;
    st = '0;
    st.found = 1'b1;
    if (act == ACT_ALLOC) begin
      run = 0;
      start = 0;
      hit = 1'b0;
      if (len != 0) begin
        for (f = 0; f < Frames && !hit; f++) begin
          if (frame_taken[f]) begin
            run = 0;
            start = f + 1;
          end else begin
            run++;
            if (run == int'(len)) hit = 1'b1;
          end
        end
      end
      if (hit) begin
        for (f = start; f < start + int'(len); f++) begin
          frame_taken[f] = 1'b1;
          if (model_free > 0) model_free--;
          if (model_used < Frames) model_used++;
        end
        st.first_frame = start[FrameW-1:0];
        alloc_hits++;
      end else begin
        st.found = 1'b0;
        alloc_misses++;
      end
    end else begin
      stop = int'(first) + int'(len);
      if (stop > Frames) stop = Frames;
      for (f = int'(first); f < stop; f++) begin
        if (act == ACT_RESERVE) begin
          if (!frame_taken[f]) begin
            frame_taken[f] = 1'b1;
            if (model_free > 0) model_free--;
          end
        end else if (frame_taken[f]) begin
          frame_taken[f] = 1'b0;
          if (model_free < Frames) model_free++;
          if (act == ACT_FREE && model_used > 0) model_used--;
        end
      end
      run_updates++;
    end
    st.free_count = model_free[CntW-1:0];
    st.used_count = model_used[CntW-1:0];
    return st;
  endfunction

  function automatic status_t queue_op(act_e act, int first, int len, bit drain);
    op_t op;
    op.act = act;
    op.first = first[FrameW-1:0];
    op.len = len[LenW-1:0];
    op.drain = drain;
    op.status = predict_status(op.act, op.first, op.len);
    pending_ops.push_back(op);
    return op.status;
  endfunction

  function automatic int alloc_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 8);
    if (r < 90) return $urandom_range(9, 64);
    if (r < 98) return $urandom_range(65, 512);
    return $urandom_range(513, 4096);
  endfunction

  function automatic int draw_gap();
    if (burst_mode) return 0;
    return $urandom_range(0, 10);
  endfunction

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Driver: presents queued transactions at the falling edge.
  always @(negedge clk_i) begin
    logic v;
    v = in_valid_i;
    if (rst_ni) begin
      if (in_fire) begin
        awaited_status.push_back(cur_op.status);
        v = 1'b0;
        send_gap = draw_gap();
      end
      if (!v && pending_ops.size() > 0) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (!(pending_ops[0].drain && awaited_status.size() != 0)) begin
          cur_op = pending_ops.pop_front();
          action_i <= cur_op.act;
          first_frame_in_i <= cur_op.first;
          run_length_i <= cur_op.len;
          v = 1'b1;
        end
      end
    end
    in_valid_i <= v;
  end

  // Result side stalls for a random number of cycles after each transaction.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (out_fire) recv_stall = draw_gap();
      if (recv_stall > 0) begin
        recv_stall--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  task automatic check_field(string name, int exp_val, int act_val);
    if (exp_val != act_val) begin
      $error("%s: expected %0d, got %0d", name, exp_val, act_val);
      errors++;
    end
  endtask

  // Monitor: samples handshakes at the rising edge and checks each result.
  always @(posedge clk_i) begin
    status_t exp_st;
    if (rst_ni) begin
      in_fire = in_valid_i && in_ready_o;
      out_fire = out_valid_o && out_ready_i;
      if (out_fire) begin
        if (awaited_status.size() == 0) begin
          $error("Result transaction arrived with no expected status pending");
          errors++;
        end else begin
          exp_st = awaited_status.pop_front();
          check_field("first_frame_out", exp_st.first_frame, first_frame_out_o);
          check_field("found", exp_st.found, found_o);
          check_field("free_count", exp_st.free_count, free_count_o);
          check_field("used_count", exp_st.used_count, used_count_o);
          checked++;
        end
      end
      if (in_fire || out_fire) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IdleLimit) begin
        $display("Watchdog expired after %0d idle cycles", idle_cycles);
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  initial begin
    status_t st;
    run_t    r;
    int      n;
    int      sel;
    int      idx;
    int      len;
    int      first;
    act_e    act;

    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    action_i = ACT_ALLOC;
    first_frame_in_i = '0;
    run_length_i = '0;
    out_ready_i = 1'b0;
    in_fire = 1'b0;
    out_fire = 1'b0;
    send_gap = 0;
    recv_stall = 0;
    burst_mode = 1'b0;
    idle_cycles = 0;
    errors = 0;
    checked = 0;
    alloc_hits = 0;
    alloc_misses = 0;
    run_updates = 0;
    for (n = 0; n < Frames; n++) frame_taken[n] = 1'b1;
    model_free = 0;
    model_used = 0;

    // Directed part: empty map, zero lengths, whole-map runs, saturation of
    // the used count, frames past the end and freeing frames that are free.
    st = queue_op(ACT_ALLOC, 0, 1, 0);
    st = queue_op(ACT_ALLOC, 'hFFF, 0, 0);
    st = queue_op(ACT_FREE, 0, 4096, 0);
    st = queue_op(ACT_RELEASE, 0, 0, 0);
    st = queue_op(ACT_ALLOC, 0, 4096, 0);
    st = queue_op(ACT_RELEASE, 0, 4096, 1);
    st = queue_op(ACT_ALLOC, 0, 1, 0);
    st = queue_op(ACT_ALLOC, 0, 'h1FFF, 0);
    st = queue_op(ACT_RESERVE, 'hFFF, 'h1FFF, 0);
    st = queue_op(ACT_ALLOC, 0, 4095, 0);
    st = queue_op(ACT_ALLOC, 0, 4094, 0);
    st = queue_op(ACT_FREE, 0, 4096, 0);
    st = queue_op(ACT_RELEASE, 'hFFF, 1, 0);
    st = queue_op(ACT_FREE, 2048, 2048, 0);
    st = queue_op(ACT_RESERVE, 0, 4096, 0);
    st = queue_op(ACT_RELEASE, 'hAAA, 'h555, 0);
    st = queue_op(ACT_ALLOC, 0, 'h155, 0);
    st = queue_op(ACT_RELEASE, 'h555, 'hAAA, 0);
    st = queue_op(ACT_ALLOC, 0, 1, 0);
    st = queue_op(ACT_RESERVE, 100, 7, 0);
    st = queue_op(ACT_ALLOC, 0, 3, 0);
    st = queue_op(ACT_RELEASE, 0, 4096, 0);

    // Random part: mostly allocations and frees of live runs, with some
    // release, reserve and unconstrained transactions mixed in.
    for (n = 0; n < 1150; n++) begin
      sel = $urandom_range(0, 99);
      if (n % 150 == 149) begin
        st = queue_op(ACT_RELEASE, 0, 4096, 0);
        live_runs.delete();
      end else if (sel < 8) begin
        act = act_e'($urandom_range(0, 3));
        st = queue_op(act, $urandom_range(0, 4095), $urandom_range(0, 8191), 0);
      end else if (sel < 50 || live_runs.size() == 0) begin
        len = alloc_length();
        st = queue_op(ACT_ALLOC, $urandom_range(0, 4095), len, n % 250 == 125);
        if (st.found) begin
          r.start = st.first_frame;
          r.len = len[LenW-1:0];
          live_runs.push_back(r);
        end
      end else if (sel < 85) begin
        idx = $urandom_range(0, live_runs.size() - 1);
        r = live_runs[idx];
        live_runs.delete(idx);
        first = r.start;
        len = r.len;
        if ($urandom_range(0, 4) == 0) begin
          first = first + $urandom_range(0, len - 1);
          len = $urandom_range(1, r.start + r.len - first);
        end
        st = queue_op(ACT_FREE, first, len, 0);
      end else if (sel < 93) begin
        st = queue_op(ACT_RELEASE, $urandom_range(0, 1023), $urandom_range(1, 64), 0);
      end else begin
        st = queue_op(ACT_RESERVE, $urandom_range(0, 1023), $urandom_range(1, 16), 0);
      end
    end

    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    n = 0;
    while (pending_ops.size() != 0 || in_valid_i || awaited_status.size() != 0) begin
      @(posedge clk_i);
      n++;
      burst_mode = (n / 3000) % 4 == 3;
    end
    burst_mode = 1'b0;
    repeat (1100) @(posedge clk_i);

    $display("Checked %0d results: %0d allocations found a run, %0d did not,",
             checked, alloc_hits, alloc_misses);
    $display("and %0d free, release and reserve transactions.", run_updates);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
